// ===== src/tlv_discovery_packet_parser_defines.svh =====
// Assertion macros used by the checker of the discovery packet parser.
// Depends on nothing; included by the checker only.
`ifndef TLV_DISCOVERY_PACKET_PARSER_DEFINES_SVH
`define TLV_DISCOVERY_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TDP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdp checker: same-cycle implication failed");

// Next-cycle implication, switched off while reset is high.
`define TDP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdp checker: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define TDP_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tdp checker: next-cycle implication failed");

`endif

// ===== src/tdp_pkg.sv =====
// Package of the discovery packet parser: header layout constants, result codes and types.
// Depends on nothing; used by the result queue, the parser and the checker.
package tdp_pkg;

   localparam int HEADER_BYTES      = 32;
   localparam int PROP_HEADER_BYTES = 4;
   localparam int RESULT_DEPTH      = 4;

   localparam logic [15:0] OPCODE_OFFSET = 16'h0001;
   localparam logic [15:0] CLIENT_OFFSET = 16'h0008;
   localparam logic [15:0] SERVER_OFFSET = 16'h000e;
   localparam logic [15:0] SEQ_OFFSET    = 16'h0016;
   localparam logic [15:0] SIG_OFFSET    = 16'h0018;
   localparam int          MAC_BYTES     = 6;
   localparam int          SIG_BYTES     = 4;
   localparam logic [7:0]  VERSION_VALUE = 8'h01;
   localparam logic [15:0] TERM_TAG_RESET = 16'hffff;

   typedef enum logic [1:0] {
      KIND_HEADER      = 2'd0,
      KIND_PROP_HEADER = 2'd1,
      KIND_PROP_DATA   = 2'd2,
      KIND_END         = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_AFTER_TERM = 2'd2,
      STATUS_TRUNCATED  = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  opcode;
      logic [47:0] client_addr;
      logic [47:0] server_addr;
      logic [15:0] sequence_res;
      logic [15:0] tag;
      logic [15:0] length;
      logic [7:0]  payload;
      status_type  status;
      logic [15:0] byte_count;
      logic        last_of_run;
   } result_type;

   // Results written into the queue in one cycle: none, one or two.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Expected signature byte at a given offset within the signature.
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0: value = 8'h4e;
         2'd1: value = 8'h53;
         2'd2: value = 8'h44;
         default: value = 8'h50;
      endcase
      return value;
   endfunction

endpackage

// ===== src/tdp_req_if.sv =====
// Byte input channel of the discovery packet parser.
// Depends on nothing.
interface tdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/tdp_rsp_if.sv =====
// Result channel of the discovery packet parser.
// Depends on nothing.
interface tdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  opcode;
   logic [47:0] client_addr;
   logic [47:0] server_addr;
   logic [15:0] sequence_res;
   logic [15:0] tag;
   logic [15:0] length;
   logic [7:0]  payload;
   logic [1:0]  status;
   logic [15:0] byte_count;
   logic        last_of_run;

   modport source (output valid, output kind, output opcode, output client_addr,
                   output server_addr, output sequence_res, output tag, output length,
                   output payload, output status, output byte_count, output last_of_run,
                   input ready);
   modport sink (input valid, input kind, input opcode, input client_addr,
                 input server_addr, input sequence_res, input tag, input length,
                 input payload, input status, input byte_count, input last_of_run,
                 output ready);
endinterface

// ===== src/tdp_csr_if.sv =====
// Configuration write channel of the discovery packet parser (terminator tag).
// Depends on nothing.
interface tdp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] terminator_tag;

   modport source (output valid, output terminator_tag, input ready);
   modport sink (input valid, input terminator_tag, output ready);
endinterface

// ===== src/tdp_result_fifo.sv =====
// Small result queue of the discovery packet parser: takes up to two results a cycle,
// gives at most one a cycle. Depends on tdp_pkg.
module tdp_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  tdp_pkg::push_type   push,
   input  logic                pop,
   output logic                room_for_two,
   output logic                head_valid,
   output tdp_pkg::result_type head
);

   localparam int PTR_W = $clog2(tdp_pkg::RESULT_DEPTH);
   localparam int CNT_W = $clog2(tdp_pkg::RESULT_DEPTH + 1);

   tdp_pkg::result_type entry_ff [tdp_pkg::RESULT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_next;

   assign wr_next      = PTR_W'(wr_ptr_ff + 1'b1);
   assign head_valid   = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CNT_W'(tdp_pkg::RESULT_DEPTH - 2));

   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + push.count);
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push.count) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== src/tlv_discovery_packet_parser.sv =====
// Discovery datagram parser: one byte in, header fields, properties and an end status out.
// A result is registered and can be transferred out in the cycle after its byte. One byte
// is taken per cycle. A byte may yield two results; they fill two slots of a four-entry
// queue that drains at most one result per cycle, and input waits while fewer than two
// slots are free. Synchronous reset clears the parser, empties the queue and returns the
// terminator tag to 0xFFFF. Depends on tdp_pkg, the interfaces and tdp_result_fifo.
module tlv_discovery_packet_parser (
   input logic        clock,
   input logic        reset,
   tdp_req_if.sink    req_bus,
   tdp_rsp_if.source  rsp_bus,
   tdp_csr_if.sink    csr_bus
);

   localparam logic [15:0] HDR_LAST   = 16'(tdp_pkg::HEADER_BYTES - 1);
   localparam logic [15:0] HDR_BYTES  = 16'(tdp_pkg::HEADER_BYTES);
   localparam logic [15:0] SHORT_LAST =
      16'(tdp_pkg::HEADER_BYTES + tdp_pkg::PROP_HEADER_BYTES - 1);
   localparam logic [16:0] PROP_HDR   = 17'(tdp_pkg::PROP_HEADER_BYTES);

   // Saturating add used for the consumed byte count.
   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] b);
      logic [17:0] sum;
      sum = {2'b00, a} + {1'b0, b};
      return (sum > 18'h0ffff) ? 16'hffff : sum[15:0];
   endfunction

   // Configuration register.
   logic [15:0] term_tag_ff;

   // Per-datagram control state.
   logic [15:0]          byte_pos_ff,  byte_pos_in;
   logic                 header_ok_ff, header_ok_in;
   logic [1:0]           prop_idx_ff,  prop_idx_in;
   logic [15:0]          remain_ff,    remain_in;
   logic                 term_seen_ff, term_seen_in;
   tdp_pkg::status_type  error_ff,     error_in;
   logic [15:0]          consumed_ff,  consumed_in;

   // Captured header and property fields; each is fully written before it is shown.
   logic [7:0]  op_ff,     op_in;
   logic [47:0] client_ff, client_in;
   logic [47:0] server_ff, server_in;
   logic [15:0] seq_ff,    seq_in;
   logic [15:0] tag_ff,    tag_in;
   logic [15:0] len_ff,    len_in;

   logic                accept;
   logic                room_for_two;
   logic                head_valid;
   tdp_pkg::result_type head;
   tdp_pkg::push_type   push;
   tdp_pkg::result_type item_res;
   tdp_pkg::result_type end_res;
   logic                item_emit;
   tdp_pkg::status_type end_status;
   logic [15:0]         pos;
   logic [7:0]          b;

   // A new byte is taken only while two queue slots are free, so that a byte that ends a
   // datagram together with a property or header result never overflows the queue.
   assign req_bus.ready = room_for_two;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign pos           = byte_pos_ff;
   assign b             = req_bus.data_byte;

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      header_ok_in = header_ok_ff;
      prop_idx_in  = prop_idx_ff;
      remain_in    = remain_ff;
      term_seen_in = term_seen_ff;
      error_in     = error_ff;
      consumed_in  = consumed_ff;
      op_in        = op_ff;
      client_in    = client_ff;
      server_in    = server_ff;
      seq_in       = seq_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      item_res     = '0;
      end_res      = '0;
      item_emit    = 1'b0;
      end_status   = tdp_pkg::STATUS_OK;
      push         = '0;

      if (accept) begin
         if (pos < HDR_BYTES) begin
            // Fixed header: check version and signature, capture the fields.
            if (pos == 16'd0 && b != tdp_pkg::VERSION_VALUE) begin
               header_ok_in = 1'b0;
            end
            if (pos >= tdp_pkg::SIG_OFFSET
                && pos < tdp_pkg::SIG_OFFSET + 16'(tdp_pkg::SIG_BYTES)
                && b != tdp_pkg::sig_byte(2'(pos - tdp_pkg::SIG_OFFSET))) begin
               header_ok_in = 1'b0;
            end
            if (pos == tdp_pkg::OPCODE_OFFSET) begin
               op_in = b;
            end
            if (pos >= tdp_pkg::CLIENT_OFFSET
                && pos < tdp_pkg::CLIENT_OFFSET + 16'(tdp_pkg::MAC_BYTES)) begin
               client_in = {client_ff[39:0], b};
            end
            if (pos >= tdp_pkg::SERVER_OFFSET
                && pos < tdp_pkg::SERVER_OFFSET + 16'(tdp_pkg::MAC_BYTES)) begin
               server_in = {server_ff[39:0], b};
            end
            if (pos == tdp_pkg::SEQ_OFFSET || pos == tdp_pkg::SEQ_OFFSET + 16'd1) begin
               seq_in = {seq_ff[7:0], b};
            end
            if (pos == HDR_LAST && header_ok_in) begin
               item_emit             = 1'b1;
               item_res.kind         = tdp_pkg::KIND_HEADER;
               item_res.opcode       = op_in;
               item_res.client_addr  = client_in;
               item_res.server_addr  = server_in;
               item_res.sequence_res = seq_in;
            end
         end else if (header_ok_ff && error_ff == tdp_pkg::STATUS_OK) begin
            if (remain_ff != 16'd0) begin
               // Data byte of the current property.
               item_emit        = 1'b1;
               item_res.kind    = tdp_pkg::KIND_PROP_DATA;
               item_res.payload = b;
               remain_in        = remain_ff - 16'd1;
               if (remain_ff == 16'd1) begin
                  consumed_in = sat_add(consumed_ff, PROP_HDR + {1'b0, len_ff});
               end
            end else begin
               // Property header: big-endian tag, then big-endian length.
               case (prop_idx_ff)
                  2'd0: tag_in = {b, tag_ff[7:0]};
                  2'd1: tag_in = {tag_ff[15:8], b};
                  2'd2: len_in = {b, len_ff[7:0]};
                  default: len_in = {len_ff[15:8], b};
               endcase
               if (prop_idx_ff == 2'd3) begin
                  prop_idx_in = 2'd0;
                  if (term_seen_ff) begin
                     error_in = tdp_pkg::STATUS_AFTER_TERM;
                  end else begin
                     item_emit       = 1'b1;
                     item_res.kind   = tdp_pkg::KIND_PROP_HEADER;
                     item_res.tag    = tag_in;
                     item_res.length = len_in;
                     if (tag_in == term_tag_ff) begin
                        term_seen_in = 1'b1;
                     end
                     remain_in = len_in;
                     if (len_in == 16'd0) begin
                        consumed_in = sat_add(consumed_ff, PROP_HDR);
                     end
                  end
               end else begin
                  prop_idx_in = prop_idx_ff + 2'd1;
               end
            end
         end

         if (byte_pos_ff != 16'hffff) begin
            byte_pos_in = byte_pos_ff + 16'd1;
         end

         if (req_bus.last_byte) begin
            // End of datagram: a bad or short header outranks a recorded error, which
            // outranks a property whose data is still owed.
            if (!header_ok_in || pos < SHORT_LAST) begin
               end_status = tdp_pkg::STATUS_BAD_HEADER;
            end else if (error_in != tdp_pkg::STATUS_OK) begin
               end_status = error_in;
            end else if (remain_in != 16'd0) begin
               end_status = tdp_pkg::STATUS_TRUNCATED;
            end else begin
               end_status = tdp_pkg::STATUS_OK;
            end
            end_res.kind        = tdp_pkg::KIND_END;
            end_res.status      = end_status;
            end_res.byte_count  = (end_status == tdp_pkg::STATUS_BAD_HEADER) ?
                                  16'd0 : consumed_in;
            end_res.last_of_run = 1'b1;

            byte_pos_in  = 16'd0;
            header_ok_in = 1'b1;
            prop_idx_in  = 2'd0;
            remain_in    = 16'd0;
            term_seen_in = 1'b0;
            error_in     = tdp_pkg::STATUS_OK;
            consumed_in  = HDR_BYTES;
            op_in        = '0;
            client_in    = '0;
            server_in    = '0;
            seq_in       = '0;
            tag_in       = '0;
            len_in       = '0;
         end

         if (item_emit && req_bus.last_byte) begin
            push.count  = 2'd2;
            push.first  = item_res;
            push.second = end_res;
         end else if (item_emit) begin
            push.count             = 2'd1;
            push.first             = item_res;
            push.first.last_of_run = 1'b1;
         end else if (req_bus.last_byte) begin
            push.count = 2'd1;
            push.first = end_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_tag_ff  <= tdp_pkg::TERM_TAG_RESET;
         byte_pos_ff  <= 16'd0;
         header_ok_ff <= 1'b1;
         prop_idx_ff  <= 2'd0;
         remain_ff    <= 16'd0;
         term_seen_ff <= 1'b0;
         error_ff     <= tdp_pkg::STATUS_OK;
         consumed_ff  <= HDR_BYTES;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            term_tag_ff <= csr_bus.terminator_tag;
         end
         byte_pos_ff  <= byte_pos_in;
         header_ok_ff <= header_ok_in;
         prop_idx_ff  <= prop_idx_in;
         remain_ff    <= remain_in;
         term_seen_ff <= term_seen_in;
         error_ff     <= error_in;
         consumed_ff  <= consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      client_ff <= client_in;
      server_ff <= server_in;
      seq_ff    <= seq_in;
      tag_ff    <= tag_in;
      len_ff    <= len_in;
   end

   // The queue parts the parser from the result channel: results waiting to be transferred
   // out hold up the next input byte only while fewer than two queue slots are free.
   tdp_result_fifo u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop          (rsp_bus.valid && rsp_bus.ready),
      .room_for_two (room_for_two),
      .head_valid   (head_valid),
      .head         (head)
   );

   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.kind         = head.kind;
   assign rsp_bus.opcode       = head.opcode;
   assign rsp_bus.client_addr  = head.client_addr;
   assign rsp_bus.server_addr  = head.server_addr;
   assign rsp_bus.sequence_res = head.sequence_res;
   assign rsp_bus.tag          = head.tag;
   assign rsp_bus.length       = head.length;
   assign rsp_bus.payload      = head.payload;
   assign rsp_bus.status       = head.status;
   assign rsp_bus.byte_count   = head.byte_count;
   assign rsp_bus.last_of_run  = head.last_of_run;

endmodule

// ===== src/tdp_checker.sv =====
// Port-level checker of the discovery packet parser, bound to the top level.
// Depends on tdp_pkg and tlv_discovery_packet_parser_defines.svh.
`include "tlv_discovery_packet_parser_defines.svh"

module tdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_byte_count,
   input logic        rsp_last_of_run
);

   logic        rsp_stalled;
   logic        end_shown;
   logic        end_bad;
   logic        end_good;
   logic [17:0] shown_fields;

   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign end_shown    = rsp_valid && rsp_kind == tdp_pkg::KIND_END;
   assign end_bad      = end_shown && rsp_status == tdp_pkg::STATUS_BAD_HEADER;
   assign end_good     = end_shown && rsp_status != tdp_pkg::STATUS_BAD_HEADER;
   assign shown_fields = {rsp_kind, rsp_byte_count};

   `TDP_ASSERT_NXT_ALL(a_empty_after_reset, clock, reset, !rsp_valid)

   `TDP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(shown_fields))

   `TDP_ASSERT_IMP(a_end_closes_run, clock, reset, end_shown, rsp_last_of_run)

   `TDP_ASSERT_IMP(a_bad_count_zero, clock, reset, end_bad, rsp_byte_count == 16'd0)

   `TDP_ASSERT_IMP(a_count_has_header, clock, reset, end_good, rsp_byte_count >= 16'd32)

endmodule

bind tlv_discovery_packet_parser tdp_checker u_tdp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_status      (rsp_bus.status),
   .rsp_byte_count  (rsp_bus.byte_count),
   .rsp_last_of_run (rsp_bus.last_of_run)
);
